[sv/fevd_pkg.sv]
package fevd_pkg;

    localparam int unsigned WIN_BITS  = 13;
    localparam int unsigned SUM_BITS  = 28;
    localparam int unsigned IDX_BITS  = 16;
    localparam int unsigned HOP_BITS  = 12;
    localparam int unsigned NUM_SLOTS = 3;
    localparam int unsigned SLOT_BITS = 2;
    localparam int unsigned APB_ADDR_BITS = 3;
    localparam int unsigned APB_DATA_BITS = 32;

    localparam logic [WIN_BITS-1:0] WIN_MIN   = 13'd2;
    localparam logic [WIN_BITS-1:0] WIN_MAX   = 13'd4096;
    localparam logic [WIN_BITS-1:0] WIN_RESET = 13'd441;

    localparam logic [SUM_BITS-1:0] SUM_LIMIT   = {SUM_BITS{1'b1}};
    localparam logic [WIN_BITS-1:0] COUNT_LIMIT = {WIN_BITS{1'b1}};

    typedef enum logic
    {
        REG_WINDOW_LEN       = 1'b0,
        REG_ENERGY_THRESHOLD = 1'b1
    } reg_idx_t;

    // Settings the back end needs, window already clamped to its legal range
    typedef struct packed
    {
        logic [WIN_BITS-1:0] win;
        logic [SUM_BITS-1:0] threshold;
    } cfg_t;

    function automatic logic [SLOT_BITS-1:0] slot_inc(input logic [SLOT_BITS-1:0] s);
        logic [SLOT_BITS-1:0] r;
        if (s == SLOT_BITS'(NUM_SLOTS - 1))
        begin
            r = '0;
        end
        else
        begin
            r = s + 1'b1;
        end
        return r;
    endfunction

endpackage

[sv/fevd_front.sv]
module fevd_front #(
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          last,
    input  logic                          in_valid,
    output logic                          in_ready,
    output logic                          item_valid,
    input  logic                          item_ready,
    output logic        [SAMPLE_BITS-1:0] item_mag,
    output logic                          item_neg,
    output logic                          item_last
);
    import fevd_pkg::*;

    logic [SAMPLE_BITS-1:0] mag_reg [2];
    logic                   neg_reg [2];
    logic                   last_reg [2];
    logic                   wr_ptr_reg, wr_ptr_next;
    logic                   rd_ptr_reg, rd_ptr_next;
    logic [1:0]             count_reg, count_next;

    logic [SAMPLE_BITS-1:0] raw;
    logic [SAMPLE_BITS-1:0] mag;
    logic                   neg;
    logic                   push;
    logic                   pop;

    assign raw = sample;
    assign neg = raw[SAMPLE_BITS-1];
    // two's complement negate; the most negative code maps onto itself as unsigned
    assign mag = neg ? ((~raw) + {{(SAMPLE_BITS-1){1'b0}}, 1'b1}) : raw;

    assign in_ready   = (count_reg != 2'd2);
    assign item_valid = (count_reg != 2'd0);
    assign push       = in_valid && in_ready;
    assign pop        = item_valid && item_ready;

    assign item_mag  = mag_reg[rd_ptr_reg];
    assign item_neg  = neg_reg[rd_ptr_reg];
    assign item_last = last_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mag_reg[wr_ptr_reg]  <= mag;
            neg_reg[wr_ptr_reg]  <= neg;
            last_reg[wr_ptr_reg] <= last;
        end
    end

endmodule

[sv/fevd_back.sv]
module fevd_back #(
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  fevd_pkg::cfg_t                   cfg,
    input  logic                             item_valid,
    output logic                             item_ready,
    input  logic [SAMPLE_BITS-1:0]           item_mag,
    input  logic                             item_neg,
    input  logic                             item_last,
    output logic                             result_valid,
    input  logic                             result_ready,
    output logic [fevd_pkg::IDX_BITS-1:0]    frame_index,
    output logic [fevd_pkg::SUM_BITS-1:0]    abs_sum,
    output logic [fevd_pkg::WIN_BITS-1:0]    sign_changes,
    output logic                             is_voice,
    output logic                             final_result
);
    import fevd_pkg::*;

    // per-slot frame state
    logic [SUM_BITS-1:0]  sum_reg   [NUM_SLOTS];
    logic [SUM_BITS-1:0]  sum_next  [NUM_SLOTS];
    logic [WIN_BITS-1:0]  cnt_reg   [NUM_SLOTS];
    logic [WIN_BITS-1:0]  cnt_next  [NUM_SLOTS];
    logic [WIN_BITS-1:0]  fill_reg  [NUM_SLOTS];
    logic [WIN_BITS-1:0]  fill_next [NUM_SLOTS];
    logic [IDX_BITS-1:0]  frame_reg [NUM_SLOTS];
    logic [IDX_BITS-1:0]  frame_next[NUM_SLOTS];
    logic [NUM_SLOTS-1:0] prev_neg_reg, prev_neg_next;
    logic [NUM_SLOTS-1:0] active_reg, active_next;
    logic [NUM_SLOTS-1:0] pend_reg, pend_next;

    logic [SLOT_BITS-1:0] base_reg, base_next;
    logic                 final_pend_reg, final_pend_next;
    logic [HOP_BITS-1:0]  hop_reg, hop_next;
    logic [IDX_BITS-1:0]  fidx_reg, fidx_next;
    logic [SLOT_BITS-1:0] nslot_reg, nslot_next;

    logic                 out_valid_reg, out_valid_next;
    logic [IDX_BITS-1:0]  out_index_reg;
    logic [SUM_BITS-1:0]  out_sum_reg;
    logic [WIN_BITS-1:0]  out_cnt_reg;
    logic                 out_voice_reg;
    logic                 out_final_reg;

    logic [SLOT_BITS-1:0] order [NUM_SLOTS];
    logic [SLOT_BITS-1:0] emit_sel;
    logic [NUM_SLOTS-1:0] emit_hot;
    logic [NUM_SLOTS-1:0] rest;
    logic                 can_load;
    logic                 emit;
    logic                 pop;
    logic                 open_frame;
    logic [HOP_BITS-1:0]  hop_len;
    logic [SLOT_BITS-1:0] nslot_open;

    assign hop_len    = cfg.win[WIN_BITS-1:1];
    assign open_frame = (hop_reg == '0);
    assign nslot_open = open_frame ? slot_inc(nslot_reg) : nslot_reg;

    // oldest pending frame first, counted from the slot after the newest
    always_comb
    begin
        logic found;
        order[0] = base_reg;
        order[1] = slot_inc(base_reg);
        order[2] = slot_inc(order[1]);
        found    = 1'b0;
        emit_sel = base_reg;
        emit_hot = '0;
        for (int k = 0; k < NUM_SLOTS; k++)
        begin
            if (!found && pend_reg[order[k]])
            begin
                found              = 1'b1;
                emit_sel           = order[k];
                emit_hot[order[k]] = 1'b1;
            end
        end
    end

    assign can_load   = !out_valid_reg || result_ready;
    assign emit       = can_load && (pend_reg != '0);
    assign rest       = pend_reg & ~emit_hot;
    assign item_ready = (pend_reg == '0) || (emit && (rest == '0));
    assign pop        = item_valid && item_ready;

    always_comb
    begin
        logic                opening;
        logic [SUM_BITS-1:0] cur_sum;
        logic [WIN_BITS-1:0] cur_cnt;
        logic [WIN_BITS-1:0] cur_fill;
        logic                cur_prev;
        logic [SUM_BITS:0]   wide_sum;
        logic                done;

        prev_neg_next = prev_neg_reg;
        active_next   = active_reg;
        pend_next     = rest & {NUM_SLOTS{emit}} | (pend_reg & {NUM_SLOTS{!emit}});
        for (int s = 0; s < NUM_SLOTS; s++)
        begin
            opening  = open_frame && (nslot_reg == SLOT_BITS'(s));
            cur_sum  = opening ? '0 : sum_reg[s];
            cur_cnt  = opening ? '0 : cnt_reg[s];
            cur_fill = opening ? '0 : fill_reg[s];
            cur_prev = opening ? 1'b0 : prev_neg_reg[s];
            wide_sum = {1'b0, cur_sum} + (SUM_BITS+1)'(item_mag);
            done     = 1'b0;

            sum_next[s]   = sum_reg[s];
            cnt_next[s]   = cnt_reg[s];
            fill_next[s]  = fill_reg[s];
            frame_next[s] = (pop && opening) ? fidx_reg : frame_reg[s];

            if (pop && (opening || active_reg[s]))
            begin
                sum_next[s] = wide_sum[SUM_BITS] ? SUM_LIMIT : wide_sum[SUM_BITS-1:0];
                cnt_next[s] = ((item_neg != cur_prev) && (cur_cnt != COUNT_LIMIT)) ?
                              cur_cnt + 1'b1 : cur_cnt;
                fill_next[s] = (cur_fill != COUNT_LIMIT) ? cur_fill + 1'b1 : cur_fill;
                prev_neg_next[s] = item_neg;
                done = (fill_next[s] >= cfg.win) || item_last;
                active_next[s] = !done;
                if (done)
                begin
                    pend_next[s] = 1'b1;
                end
            end
            else if (pop && opening)
            begin
                active_next[s] = 1'b1;
            end
        end
    end

    always_comb
    begin
        hop_next        = hop_reg;
        fidx_next       = fidx_reg;
        nslot_next      = nslot_reg;
        base_next       = base_reg;
        final_pend_next = final_pend_reg;
        if (pop)
        begin
            base_next       = nslot_open;
            final_pend_next = item_last;
            if (item_last)
            begin
                hop_next   = '0;
                fidx_next  = '0;
                nslot_next = '0;
            end
            else
            begin
                hop_next   = open_frame ? hop_len - 1'b1 : hop_reg - 1'b1;
                fidx_next  = open_frame ? fidx_reg + 1'b1 : fidx_reg;
                nslot_next = nslot_open;
            end
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= '0;
            pend_reg       <= '0;
            base_reg       <= '0;
            final_pend_reg <= 1'b0;
            hop_reg        <= '0;
            fidx_reg       <= '0;
            nslot_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            active_reg     <= active_next;
            pend_reg       <= pend_next;
            base_reg       <= base_next;
            final_pend_reg <= final_pend_next;
            hop_reg        <= hop_next;
            fidx_reg       <= fidx_next;
            nslot_reg      <= nslot_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < NUM_SLOTS; s++)
        begin
            sum_reg[s]   <= sum_next[s];
            cnt_reg[s]   <= cnt_next[s];
            fill_reg[s]  <= fill_next[s];
            frame_reg[s] <= frame_next[s];
        end
        prev_neg_reg <= prev_neg_next;
        if (emit)
        begin
            out_index_reg <= frame_reg[emit_sel];
            out_sum_reg   <= sum_reg[emit_sel];
            out_cnt_reg   <= cnt_reg[emit_sel];
            out_voice_reg <= (sum_reg[emit_sel] > cfg.threshold);
            out_final_reg <= final_pend_reg && (rest == '0);
        end
    end

    assign result_valid = out_valid_reg;
    assign frame_index  = out_index_reg;
    assign abs_sum      = out_sum_reg;
    assign sign_changes = out_cnt_reg;
    assign is_voice     = out_voice_reg;
    assign final_result = out_final_reg;

`ifndef SYNTHESIS
    a_pend_not_active: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg & active_reg) == '0)
        else $error("slot both pending and accumulating");

    a_no_pop_with_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        ($countones(pend_reg) > 1) |-> !pop)
        else $error("word taken while several frames wait");

    a_emit_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !pop) |=> (out_valid_reg && (pend_reg & $past(emit_hot)) == '0))
        else $error("emitted frame not cleared or not shown");

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (nslot_reg != 2'd3) && (base_reg != 2'd3))
        else $error("slot pointer out of range");
`endif

endmodule

[sv/frame_energy_voice_detector.sv]
// Frame energy and sign-change voice detector.
// Samples enter on the sample channel (sample, last) under sample_valid/sample_ready;
// one result word per closed frame leaves on the result channel (frame_index,
// abs_sum, sign_changes, is_voice, final_result) under result_valid/result_ready.
// Frames are window_len samples long and one opens every window_len/2 samples.
// The APB port holds window_len (address 0) and energy_threshold (address 4);
// write them only while no sample is in flight.
// Throughput: one sample per cycle while results are taken. A frame's closing
// sample passes the front queue and its slot before the result is loaded into the
// single output register. A last sample closes every open frame; those results
// leave one per cycle as taken; the back end stalls until the last is loaded.
// A two-word queue sits between the sample front end and the frame back end,
// so a stalled result side keeps taking samples until that queue fills.
// Reset empties the queue and all frames, sets window_len to 441 and
// energy_threshold to 0; no clearing pass is needed.
module frame_energy_voice_detector #(
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic signed [SAMPLE_BITS-1:0]        sample,
    input  logic                                 last,
    input  logic                                 sample_valid,
    output logic                                 sample_ready,
    output logic [fevd_pkg::IDX_BITS-1:0]        frame_index,
    output logic [fevd_pkg::SUM_BITS-1:0]        abs_sum,
    output logic [fevd_pkg::WIN_BITS-1:0]        sign_changes,
    output logic                                 is_voice,
    output logic                                 final_result,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [fevd_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [fevd_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [fevd_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                 pready
);
    import fevd_pkg::*;

    logic [WIN_BITS-1:0]    window_len_reg, window_len_next;
    logic [SUM_BITS-1:0]    threshold_reg, threshold_next;
    logic [WIN_BITS-1:0]    win_eff;
    reg_idx_t               reg_sel;
    logic                   wr_en;
    cfg_t                   cfg;

    logic                   item_valid;
    logic                   item_ready;
    logic [SAMPLE_BITS-1:0] item_mag;
    logic                   item_neg;
    logic                   item_last;

    assign pready  = 1'b1;
    assign reg_sel = reg_idx_t'(paddr[2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        window_len_next = window_len_reg;
        threshold_next  = threshold_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_WINDOW_LEN:       window_len_next = pwdata[WIN_BITS-1:0];
                REG_ENERGY_THRESHOLD: threshold_next  = pwdata[SUM_BITS-1:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_WINDOW_LEN:       prdata = APB_DATA_BITS'(window_len_reg);
            REG_ENERGY_THRESHOLD: prdata = APB_DATA_BITS'(threshold_reg);
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg <= WIN_RESET;
            threshold_reg  <= '0;
        end
        else
        begin
            window_len_reg <= window_len_next;
            threshold_reg  <= threshold_next;
        end
    end

    // clamp the frame length to its legal range
    always_comb
    begin
        if (window_len_reg < WIN_MIN)
        begin
            win_eff = WIN_MIN;
        end
        else if (window_len_reg > WIN_MAX)
        begin
            win_eff = WIN_MAX;
        end
        else
        begin
            win_eff = window_len_reg;
        end
        cfg.win       = win_eff;
        cfg.threshold = threshold_reg;
    end

    fevd_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample),
        .last       (last),
        .in_valid   (sample_valid),
        .in_ready   (sample_ready),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item_mag   (item_mag),
        .item_neg   (item_neg),
        .item_last  (item_last)
    );

    fevd_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item_mag     (item_mag),
        .item_neg     (item_neg),
        .item_last    (item_last),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .frame_index  (frame_index),
        .abs_sum      (abs_sum),
        .sign_changes (sign_changes),
        .is_voice     (is_voice),
        .final_result (final_result)
    );

endmodule

[bench/frame_report_checker.sv]
`timescale 1ns / 100ps

module frame_report_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic signed [15:0]                  sample,
    input  logic                                last,
    input  logic                                sample_valid,
    input  logic                                sample_ready,
    input  logic [fevd_pkg::IDX_BITS-1:0]       frame_index,
    input  logic [fevd_pkg::SUM_BITS-1:0]       abs_sum,
    input  logic [fevd_pkg::WIN_BITS-1:0]       sign_changes,
    input  logic                                is_voice,
    input  logic                                final_result,
    input  logic                                result_valid,
    input  logic                                result_ready,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fevd_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [fevd_pkg::APB_DATA_BITS-1:0]  pwdata,
    input  logic                                pready,
    output int                                  mismatches,
    output int                                  reports_pending
);

    import fevd_pkg::*;

    localparam int SAMPLE_W = 16;

    typedef struct {
        logic [IDX_BITS-1:0] frame_index;
        logic [SUM_BITS-1:0] abs_sum;
        logic [WIN_BITS-1:0] sign_changes;
        logic                is_voice;
        logic                final_result;
    } frame_report_t;

    frame_report_t frame_reports[$];
    frame_report_t oldest;

    logic [WIN_BITS-1:0] win_reg;
    logic [SUM_BITS-1:0] thr_reg;

    logic [SUM_BITS-1:0] acc_sum      [NUM_SLOTS];
    logic [WIN_BITS-1:0] acc_changes  [NUM_SLOTS];
    logic                was_negative [NUM_SLOTS];
    logic [WIN_BITS-1:0] acc_fill     [NUM_SLOTS];
    logic                slot_open    [NUM_SLOTS];
    logic [IDX_BITS-1:0] slot_frame   [NUM_SLOTS];
    logic [HOP_BITS-1:0] hop_left;
    logic [IDX_BITS-1:0] frame_ctr;
    int                  next_slot;

    task automatic clear_frames();
        int s;
        for (s = 0; s < NUM_SLOTS; s++)
        begin
            acc_sum[s]      = '0;
            acc_changes[s]  = '0;
            was_negative[s] = 1'b0;
            acc_fill[s]     = '0;
            slot_open[s]    = 1'b0;
            slot_frame[s]   = '0;
        end
        hop_left  = '0;
        frame_ctr = '0;
        next_slot = 0;
    endtask

    // Advance every open frame by one sample and queue the frames it closes
    task automatic take_sample(input logic signed [SAMPLE_W-1:0] smp, input logic lst);
        int            w;
        int            hop;
        int            mag;
        int            s;
        int            k;
        int            closing;
        int            emitted;
        logic          neg;
        longint        total;
        frame_report_t rep;
        w = int'(win_reg);
        if (w < int'(WIN_MIN))
        begin
            w = int'(WIN_MIN);
        end
        if (w > int'(WIN_MAX))
        begin
            w = int'(WIN_MAX);
        end
        hop = w / 2;
        neg = smp[SAMPLE_W-1];
        mag = neg ? -int'(smp) : int'(smp);

        if (hop_left == '0)
        begin
            // open a frame; a frame still open in that slot is dropped
            s = next_slot;
            acc_sum[s]      = '0;
            acc_changes[s]  = '0;
            was_negative[s] = 1'b0;
            acc_fill[s]     = '0;
            slot_open[s]    = 1'b1;
            slot_frame[s]   = frame_ctr;
            frame_ctr       = frame_ctr + 1'b1;
            next_slot       = (next_slot + 1) % NUM_SLOTS;
            hop_left        = HOP_BITS'(hop - 1);
        end
        else
        begin
            hop_left = hop_left - 1'b1;
        end

        for (s = 0; s < NUM_SLOTS; s++)
        begin
            if (slot_open[s])
            begin
                total = longint'(acc_sum[s]) + mag;
                acc_sum[s] = (total > longint'(SUM_LIMIT)) ? SUM_LIMIT : SUM_BITS'(total);
                if (neg != was_negative[s] && acc_changes[s] != COUNT_LIMIT)
                begin
                    acc_changes[s] = acc_changes[s] + 1'b1;
                end
                was_negative[s] = neg;
                if (acc_fill[s] != COUNT_LIMIT)
                begin
                    acc_fill[s] = acc_fill[s] + 1'b1;
                end
            end
        end

        closing = 0;
        for (k = 0; k < NUM_SLOTS; k++)
        begin
            s = (next_slot + k) % NUM_SLOTS;
            if (slot_open[s] && (int'(acc_fill[s]) >= w || lst))
            begin
                closing++;
            end
        end

        // oldest frame first, starting from the slot that opens next
        emitted = 0;
        for (k = 0; k < NUM_SLOTS; k++)
        begin
            s = (next_slot + k) % NUM_SLOTS;
            if (slot_open[s] && (int'(acc_fill[s]) >= w || lst))
            begin
                emitted++;
                rep.frame_index  = slot_frame[s];
                rep.abs_sum      = acc_sum[s];
                rep.sign_changes = acc_changes[s];
                rep.is_voice     = (acc_sum[s] > thr_reg);
                rep.final_result = lst && (emitted == closing);
                frame_reports    = {frame_reports, rep};
                slot_open[s] = 1'b0;
            end
        end

        if (lst)
        begin
            hop_left  = '0;
            frame_ctr = '0;
            next_slot = 0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg = WIN_RESET;
            thr_reg = '0;
            clear_frames();
            frame_reports.delete();
            mismatches      = 0;
            reports_pending = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (frame_reports.size() == 0)
                begin
                    if (mismatches < 10)
                    begin
                        $display("%0t: unexpected result word: frame %0d sum %0d changes %0d",
                                 $realtime, frame_index, abs_sum, sign_changes);
                    end
                    mismatches++;
                end
                else
                begin
                    oldest = frame_reports.pop_front();
                    if (frame_index !== oldest.frame_index || abs_sum !== oldest.abs_sum
                        || sign_changes !== oldest.sign_changes
                        || is_voice !== oldest.is_voice
                        || final_result !== oldest.final_result)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("%0t: result mismatch, expected frame %0d sum %0d changes %0d voice %0b final %0b",
                                     $realtime, oldest.frame_index, oldest.abs_sum,
                                     oldest.sign_changes, oldest.is_voice, oldest.final_result);
                            $display("%0t:                  actual frame %0d sum %0d changes %0d voice %0b final %0b",
                                     $realtime, frame_index, abs_sum, sign_changes,
                                     is_voice, final_result);
                        end
                        mismatches++;
                    end
                end
            end

            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[APB_ADDR_BITS-1:2]))
                    REG_WINDOW_LEN:       win_reg = pwdata[WIN_BITS-1:0];
                    REG_ENERGY_THRESHOLD: thr_reg = pwdata[SUM_BITS-1:0];
                    default:              ;
                endcase
            end

            if (sample_valid && sample_ready)
            begin
                take_sample(sample, last);
            end

            reports_pending = frame_reports.size();
        end
    end

endmodule

[bench/tb_frame_energy_voice_detector.sv]
`timescale 1ns / 100ps

module tb_frame_energy_voice_detector;

    import fevd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                       clk;
    logic                       rst_n;
    logic signed [15:0]         sample;
    logic                       last;
    logic                       sample_valid;
    logic                       sample_ready;
    logic [IDX_BITS-1:0]        frame_index;
    logic [SUM_BITS-1:0]        abs_sum;
    logic [WIN_BITS-1:0]        sign_changes;
    logic                       is_voice;
    logic                       final_result;
    logic                       result_valid;
    logic                       result_ready = 1'b0;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [APB_ADDR_BITS-1:0]   paddr;
    logic [APB_DATA_BITS-1:0]   pwdata;
    logic [APB_DATA_BITS-1:0]   prdata;
    logic                       pready;

    int mismatches;
    int reports_pending;
    int cycle_count = 0;
    int send_idle;
    int recv_stall;

    frame_energy_voice_detector DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample       (sample),
        .last         (last),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .frame_index  (frame_index),
        .abs_sum      (abs_sum),
        .sign_changes (sign_changes),
        .is_voice     (is_voice),
        .final_result (final_result),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    frame_report_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .sample          (sample),
        .last            (last),
        .sample_valid    (sample_valid),
        .sample_ready    (sample_ready),
        .frame_index     (frame_index),
        .abs_sum         (abs_sum),
        .sign_changes    (sign_changes),
        .is_voice        (is_voice),
        .final_result    (final_result),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .mismatches      (mismatches),
        .reports_pending (reports_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        result_ready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Present one word; a random idle gap with valid low may come first
    task automatic send_word(input logic signed [15:0] smp, input logic lst);
        if ($urandom_range(99) < send_idle)
        begin
            sample_valid <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(99) < send_idle);
        end
        sample       <= smp;
        last         <= lst;
        sample_valid <= 1'b1;
        @(posedge clk);
        while (!sample_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [APB_DATA_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_BITS'(4 * int'(idx));
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Hold the sender until every frame result is back and the pipeline is empty
    task automatic settle();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (reports_pending != 0)
        begin
            @(posedge clk);
        end
        repeat (12) @(posedge clk);
    endtask

    task automatic play(input int count, input logic closes);
        int                 i;
        logic signed [15:0] smp;
        for (i = 0; i < count; i++)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4: smp = 16'($urandom);
                5, 6:          smp = 16'(int'($urandom_range(8)) - 4);
                7:             smp = -16'sd32768;
                8:             smp = 16'sd32767;
                default:       smp = $urandom_range(1) ? -16'sd1 : 16'sd0;
            endcase
            send_word(smp, closes && (i == count - 1));
        end
    endtask

    function automatic logic [WIN_BITS-1:0] pick_window();
        logic [WIN_BITS-1:0] w;
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: w = WIN_BITS'($urandom_range(2, 12));
            6, 7:             w = WIN_BITS'($urandom_range(13, 40));
            8:                w = WIN_BITS'($urandom_range(1));
            default:          w = WIN_BITS'($urandom_range(4097, 8191));
        endcase
        return w;
    endfunction

    initial
    begin
        int                  phase;
        int                  phase_words;
        int                  w_eff;
        int                  len;
        int                  head;
        logic [WIN_BITS-1:0] win;
        logic [SUM_BITS-1:0] thr;

        rst_n        <= 1'b0;
        sample       <= '0;
        last         <= 1'b0;
        sample_valid <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        send_idle  = 0;
        recv_stall = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // window below range, full-scale samples, one frame per sample
        write_reg(REG_WINDOW_LEN, 1);
        write_reg(REG_ENERGY_THRESHOLD, 0);
        send_word(-16'sd32768, 1'b0);
        send_word(16'sd32767, 1'b0);
        send_word(16'sd0, 1'b0);
        send_word(-16'sd1, 1'b0);
        send_word(16'sd1, 1'b1);
        settle();

        // window above range, top threshold, partial frame flushed
        write_reg(REG_WINDOW_LEN, 8191);
        write_reg(REG_ENERGY_THRESHOLD, {SUM_BITS{1'b1}});
        send_word(16'sd32767, 1'b0);
        send_word(-16'sd32768, 1'b0);
        send_word(16'sd5, 1'b1);
        settle();

        // shrink mid-frame: the long frame closes at once, then last finds nothing open
        write_reg(REG_WINDOW_LEN, 8);
        write_reg(REG_ENERGY_THRESHOLD, 100);
        send_word(16'sd10, 1'b0);
        send_word(-16'sd20, 1'b0);
        settle();
        write_reg(REG_WINDOW_LEN, 0);
        send_word(16'sd30, 1'b0);
        send_word(-16'sd40, 1'b1);
        settle();

        // grow mid-recording: slot 0 is reopened while its frame is still open
        write_reg(REG_WINDOW_LEN, 3);
        write_reg(REG_ENERGY_THRESHOLD, 28'h1000);
        send_word(16'sd100, 1'b0);
        send_word(-16'sd200, 1'b0);
        settle();
        write_reg(REG_WINDOW_LEN, 10);
        send_word(16'sd300, 1'b0);
        send_word(-16'sd400, 1'b0);
        send_word(16'sd500, 1'b0);
        send_word(-16'sd600, 1'b0);
        send_word(16'sd700, 1'b0);
        send_word(-16'sd800, 1'b0);
        send_word(16'sd900, 1'b1);
        settle();

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle  = 0;
                    recv_stall = 0;
                end
                1:
                begin
                    send_idle  = 88;
                    recv_stall = 0;
                end
                2:
                begin
                    send_idle  = 0;
                    recv_stall = 88;
                end
                default:
                begin
                    send_idle  = 29;
                    recv_stall = 29;
                end
            endcase
            phase_words = 0;
            while (phase_words < 40)
            begin
                win = pick_window();
                w_eff = int'(win);
                if (w_eff < 2)
                begin
                    w_eff = 2;
                end
                if (w_eff > 4096)
                begin
                    w_eff = 4096;
                end
                case ($urandom_range(5))
                    0:       thr = '0;
                    1:       thr = {SUM_BITS{1'b1}};
                    default: thr = SUM_BITS'($urandom_range(0, w_eff * 20000));
                endcase
                write_reg(REG_WINDOW_LEN, win);
                write_reg(REG_ENERGY_THRESHOLD, thr);
                len = $urandom_range(1, (3 * w_eff > 60) ? 60 : 3 * w_eff);
                if (len > 1 && $urandom_range(3) == 0)
                begin
                    // change the window part way through the recording
                    head = $urandom_range(1, len - 1);
                    play(head, 1'b0);
                    settle();
                    write_reg(REG_WINDOW_LEN, pick_window());
                    play(len - head, 1'b1);
                end
                else
                begin
                    play(len, 1'b1);
                end
                settle();
                phase_words += len;
            end
        end

        recv_stall = 0;
        settle();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && reports_pending == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
